// File: rtl/riot_pkg.sv
package riot_pkg;

   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   localparam logic [4:0] OFF_PORT_A  = 5'h00;
   localparam logic [4:0] OFF_PORT_B  = 5'h02;
   localparam logic [4:0] OFF_TIMER   = 5'h04;
   localparam logic [4:0] OFF_TIM1T   = 5'h14;
   localparam logic [4:0] OFF_TIM1024 = 5'h17;

   localparam logic [1:0] SEL_DIV1    = 2'd0;
   localparam logic [1:0] SEL_DIV8    = 2'd1;
   localparam logic [1:0] SEL_DIV64   = 2'd2;
   localparam logic [1:0] SEL_DIV1024 = 2'd3;

   localparam logic [7:0] TIMER_RESET = 8'hFF;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_type;

   function automatic logic [3:0] period_shift(input logic [1:0] sel);
      logic [3:0] sh;
      case (sel)
         SEL_DIV1:  sh = 4'd0;
         SEL_DIV8:  sh = 4'd3;
         SEL_DIV64: sh = 4'd6;
         default:   sh = 4'd10;
      endcase
      return sh;
   endfunction

endpackage

// File: rtl/riot_ctrl.sv
module riot_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output riot_pkg::ctrl_type ctrl
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_RESP
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign req_ready    = (state_ff == S_IDLE) || ((state_ff == S_RESP) && rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign ctrl.capture = req_valid && req_ready;
   assign ctrl.execute = (state_ff == S_EXEC);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               state_ff     <= S_RESP;
               rsp_valid_ff <= 1'b1;
            end
            S_RESP: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= req_valid ? S_EXEC : S_IDLE;
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   a_valid_in_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid == (state_ff == S_RESP))
      else $error("rsp_valid out of step with state");

   a_capture_execs: assert property (@(posedge clock) disable iff (reset)
      ctrl.capture |=> ctrl.execute)
      else $error("captured request not executed next cycle");

   a_no_capture_in_exec: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.execute && req_ready))
      else $error("request accepted during execute");

   a_resp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

endmodule

// File: rtl/riot_dp.sv
module riot_dp #(
   parameter int RAM_BYTES = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  riot_pkg::ctrl_type ctrl,
   input  logic [1:0]         req_command,
   input  logic [9:0]         req_address,
   input  logic [7:0]         req_write_data,
   input  logic [7:0]         req_tick_cycles,
   input  logic [7:0]         req_port_a_pins,
   input  logic [7:0]         req_port_b_pins,
   output logic [7:0]         rsp_read_data
);

   localparam int IDX_W   = (RAM_BYTES > 1) ? $clog2(RAM_BYTES) : 1;
   localparam int VALID_N = (RAM_BYTES < 128) ? RAM_BYTES : 128;
   localparam int VIDX_W  = (VALID_N > 1) ? $clog2(VALID_N) : 1;
   localparam logic [9:0] RAM_BYTES_W = 10'(RAM_BYTES);

   logic [7:0]       mem [RAM_BYTES];
   logic [VALID_N-1:0] valid_ff;

   logic [1:0]       cmd_ff;
   logic [9:0]       addr_ff;
   logic [7:0]       wdata_ff;
   logic [7:0]       cycles_ff;
   logic [7:0]       pa_ff;
   logic [7:0]       pb_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [7:0]       ram_q_ff;
   logic             ram_v_ff;

   logic [7:0]       timer_ff;
   logic [1:0]       sel_ff;
   logic [9:0]       acc_ff;
   logic [7:0]       rdata_ff;

   logic [9:0]       fold;
   logic [IDX_W-1:0] idx_in;
   logic [4:0]       off;
   logic [3:0]       sh;
   logic [10:0]      acc_sum;
   logic [10:0]      periods;
   logic [9:0]       acc_in;
   logic [7:0]       timer_in;
   logic [7:0]       rdata_in;
   logic             ram_wr;
   logic             tim_wr;

   // reduce the 7-bit RAM address by subtracting RAM_BYTES up to 8 times (modulo RAM_BYTES when RAM_BYTES >= 15)
   always_comb begin
      fold = {3'b000, req_address[6:0]};
      for (int i = 0; i < 8; i++) begin
         if (fold >= RAM_BYTES_W) begin
            fold = fold - RAM_BYTES_W;
         end
      end
      idx_in = fold[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff    <= req_command;
         addr_ff   <= req_address;
         wdata_ff  <= req_write_data;
         cycles_ff <= req_tick_cycles;
         pa_ff     <= req_port_a_pins;
         pb_ff     <= req_port_b_pins;
         idx_ff    <= idx_in;
         ram_q_ff  <= mem[idx_in];
         ram_v_ff  <= valid_ff[idx_in[VIDX_W-1:0]];
      end
   end

   assign off    = addr_ff[4:0];
   assign ram_wr = ctrl.execute && (cmd_ff == riot_pkg::CMD_WRITE) && !addr_ff[9];
   assign tim_wr = ctrl.execute && (cmd_ff == riot_pkg::CMD_WRITE) && addr_ff[9]
                   && (off >= riot_pkg::OFF_TIM1T) && (off <= riot_pkg::OFF_TIM1024);

   always_ff @(posedge clock) begin
      if (ram_wr) begin
         mem[idx_ff] <= wdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ram_wr) begin
         valid_ff[idx_ff[VIDX_W-1:0]] <= 1'b1;
      end
   end

   // tick: add elapsed cycles, drain whole prescale periods
   always_comb begin
      sh       = riot_pkg::period_shift(sel_ff);
      acc_sum  = {1'b0, acc_ff} + {3'b000, cycles_ff};
      periods  = acc_sum >> sh;
      acc_in   = acc_sum[9:0] & 10'((11'd1 << sh) - 11'd1);
      if (periods >= {3'b000, timer_ff}) begin
         timer_in = 8'd0;
      end else begin
         timer_in = timer_ff - periods[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff <= riot_pkg::TIMER_RESET;
         sel_ff   <= riot_pkg::SEL_DIV1024;
         acc_ff   <= '0;
      end else if (tim_wr) begin
         timer_ff <= wdata_ff;
         sel_ff   <= off[1:0];
         acc_ff   <= '0;
      end else if (ctrl.execute && (cmd_ff == riot_pkg::CMD_TICK)) begin
         timer_ff <= timer_in;
         acc_ff   <= acc_in;
      end
   end

   always_comb begin
      rdata_in = 8'd0;
      if (cmd_ff == riot_pkg::CMD_READ) begin
         if (!addr_ff[9]) begin
            rdata_in = ram_v_ff ? ram_q_ff : 8'd0;
         end else begin
            case (off)
               riot_pkg::OFF_PORT_A: rdata_in = pa_ff;
               riot_pkg::OFF_PORT_B: rdata_in = pb_ff;
               riot_pkg::OFF_TIMER:  rdata_in = timer_ff;
               default:              rdata_in = 8'd0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.execute) begin
         rdata_ff <= rdata_in;
      end
   end

   assign rsp_read_data = rdata_ff;

endmodule

// File: rtl/riot_ram_and_interval_timer_unit.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  command, address, write_data,
//                                             tick_cycles, port_a_pins, port_b_pins
// rsp_      out        rsp_valid / rsp_ready  read_data
//
// A request passes from acceptance through the execute state to the response: the RAM read port
// registers in the accept cycle, execute updates RAM/timer and the result register.
// A new request is accepted in the cycle the previous response is taken; none is
// accepted while a request executes, even with rsp_ready held high.
// Reset is synchronous; the scratch RAM reads as zero until written (valid bits).
// A stalled response holds its data and blocks further requests.
module riot_ram_and_interval_timer_unit #(
   parameter int RAM_BYTES = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_command,
   input  logic [9:0] req_address,
   input  logic [7:0] req_write_data,
   input  logic [7:0] req_tick_cycles,
   input  logic [7:0] req_port_a_pins,
   input  logic [7:0] req_port_b_pins,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data
);

   riot_pkg::ctrl_type ctrl;

   riot_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl)
   );

   riot_dp #(
      .RAM_BYTES (RAM_BYTES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .req_command     (req_command),
      .req_address     (req_address),
      .req_write_data  (req_write_data),
      .req_tick_cycles (req_tick_cycles),
      .req_port_a_pins (req_port_a_pins),
      .req_port_b_pins (req_port_b_pins),
      .rsp_read_data   (rsp_read_data)
   );

endmodule
